### hdl/gb5_pkg.sv
// gb5_pkg: shared types, constants and kernel weights of the 5x5 Gaussian blur.
// Used by every module of the block; depends on nothing.
package gb5_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MIN_SIZE       = 5;

    localparam int PIX_W          = 8;
    localparam int COL_OUT_W      = 10;
    localparam int ROW_W          = 12;
    localparam int IW_W           = 11;
    localparam int IH_W           = 13;

    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam int KWIN           = 5;
    localparam int LINES          = KWIN - 1;
    localparam int LINE_WORD_W    = LINES * PIX_W;
    localparam int ROWSUM_W       = 14;   // widest kernel row: 49 * 255
    localparam int TOTAL_W        = 16;   // 159 * 255

    // sum / 159 as (sum * ceil(2^24 / 159)) >> 24, exact for sum <= 159 * 255
    localparam int RECIP_W        = 17;
    localparam int KDIV_SHIFT     = 24;
    localparam logic [RECIP_W-1:0] KDIV_RECIP = RECIP_W'(105518);
    localparam int PROD_W         = KDIV_SHIFT + PIX_W;

    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic [3:0] KERNEL [KWIN][KWIN] = '{
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
        '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
        '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [COL_OUT_W-1:0] out_column;
        logic [ROW_W-1:0]     out_row;
        logic                 frame_last;
    } out_item_t;

    // per-pixel control that travels beside the data path
    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [COL_OUT_W-1:0] out_column;
        logic [ROW_W-1:0]     out_row;
    } meta_t;

endpackage

### hdl/gb5_line_buf.sv
// gb5_line_buf: four line buffers packed into one word per column, one memory.
// Read-modify-write per pixel with forwarding; uses gb5_pkg.
module gb5_line_buf #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    input  logic [gb5_pkg::PIX_W-1:0]        pix_in,
    output logic                             out_valid,
    output logic [gb5_pkg::LINE_WORD_W-1:0]  out_line,
    output logic [gb5_pkg::PIX_W-1:0]        out_pix
);
    import gb5_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    // bits [7:0] hold the oldest row, [31:24] the row just above
    logic [LINE_WORD_W-1:0] mem [MAX_WIDTH];

    logic [LINE_WORD_W-1:0] rd_data_reg;
    logic                   s1_valid_reg, s1_valid_next;
    logic [AW-1:0]          s1_addr_reg;
    logic [PIX_W-1:0]       s1_pix_reg;
    logic                   fwd_reg, fwd_next;
    logic [LINE_WORD_W-1:0] fwd_data_reg;
    logic [LINE_WORD_W-1:0] line;
    logic [LINE_WORD_W-1:0] wdata;

    // previous pixel's write lands on the same edge as this read: forward it
    assign line  = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wdata = {s1_pix_reg, line[LINE_WORD_W-1:PIX_W]};

    always_comb begin
        s1_valid_next = rd_en;
        fwd_next      = rd_en && s1_valid_reg && (s1_addr_reg == rd_addr);
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            fwd_reg      <= fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s1_addr_reg  <= rd_addr;
            s1_pix_reg   <= pix_in;
            fwd_data_reg <= wdata;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_line  = line;
    assign out_pix   = s1_pix_reg;

endmodule

### hdl/gb5_conv.sv
// gb5_conv: 5x5 window, kernel sums and divide-by-159 pipeline.
// Three register stages after the window; uses gb5_pkg.
module gb5_conv (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  logic [gb5_pkg::LINE_WORD_W-1:0] in_line,
    input  logic [gb5_pkg::PIX_W-1:0]       in_pix,
    input  gb5_pkg::meta_t                  in_meta,
    output logic                            out_push,
    output gb5_pkg::out_item_t              out_item
);
    import gb5_pkg::*;

    logic [PIX_W-1:0]    win_reg [KWIN][KWIN];
    logic [ROWSUM_W-1:0] rowsum_reg [KWIN];
    logic [ROWSUM_W-1:0] rowsum_next [KWIN];
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic  v_win_reg, v_row_reg, v_tot_reg, v_prod_reg;
    meta_t meta_win_reg, meta_row_reg, meta_tot_reg, meta_prod_reg;

    // window: shift left, new column enters at the right
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            for (int r = 0; r < KWIN; r++) begin
                for (int c = 0; c < KWIN - 1; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
            end
            for (int r = 0; r < LINES; r++) begin
                win_reg[r][KWIN-1] <= in_line[r*PIX_W +: PIX_W];
            end
            win_reg[KWIN-1][KWIN-1] <= in_pix;
            meta_win_reg <= in_meta;
        end
    end

    // constant weights: shift-add per tap
    always_comb begin
        for (int r = 0; r < KWIN; r++) begin
            rowsum_next[r] = '0;
            for (int c = 0; c < KWIN; c++) begin
                rowsum_next[r] = rowsum_next[r]
                    + ROWSUM_W'(KERNEL[r][c]) * ROWSUM_W'(win_reg[r][c]);
            end
        end
    end

    always_comb begin
        total_next = '0;
        for (int r = 0; r < KWIN; r++) begin
            total_next = total_next + TOTAL_W'(rowsum_reg[r]);
        end
    end

    assign prod_next = PROD_W'(total_reg * KDIV_RECIP);

    always_ff @(posedge aclk) begin
        rowsum_reg    <= rowsum_next;
        total_reg     <= total_next;
        prod_reg      <= prod_next;
        meta_row_reg  <= meta_win_reg;
        meta_tot_reg  <= meta_row_reg;
        meta_prod_reg <= meta_tot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_win_reg  <= 1'b0;
            v_row_reg  <= 1'b0;
            v_tot_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
        end else begin
            v_win_reg  <= in_valid;
            v_row_reg  <= v_win_reg;
            v_tot_reg  <= v_row_reg;
            v_prod_reg <= v_tot_reg;
        end
    end

    assign out_push            = v_prod_reg && meta_prod_reg.emit;
    assign out_item.pixel_out  = prod_reg[KDIV_SHIFT +: PIX_W];
    assign out_item.out_column = meta_prod_reg.out_column;
    assign out_item.out_row    = meta_prod_reg.out_row;
    assign out_item.frame_last = meta_prod_reg.last;

endmodule

### hdl/gb5_out_fifo.sv
// gb5_out_fifo: small result queue that decouples the pipeline from m_ready.
// Uses gb5_pkg for the item type and depth.
module gb5_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gb5_pkg::out_item_t push_item,
    input  logic               pop,
    output logic               out_valid,
    output gb5_pkg::out_item_t out_item
);
    import gb5_pkg::*;

    localparam int PW = $clog2(OUT_FIFO_DEPTH);
    localparam int CNTW = $clog2(OUT_FIFO_DEPTH + 1);

    out_item_t       fifo_mem [OUT_FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = fifo_mem[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hdl/gaussian_blur_5x5.sv
// gaussian_blur_5x5: streaming 5x5 Gaussian smoothing, one pixel per clock unless stalled.
// Pixels enter in raster order; each pixel reads and rewrites one word of a
// MAX_WIDTH x 32-bit line memory (four previous rows of its column), and the
// 5x5 window feeds a three-stage kernel and divide-by-159 pipeline. A result
// passes the output queue on its way to m_. Border positions give none.
// The single line memory port pair sets the rate: one read and one write per
// pixel. s_ready drops only when 8 results are queued or in flight. No
// clearing pass after reset. Configure only while the block is idle.
module gaussian_blur_5x5 #(
    parameter int MAX_WIDTH = gb5_pkg::MAX_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gb5_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output gb5_pkg::out_item_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gb5_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = (CW + 1 > IW_W) ? CW + 1 : IW_W;
    localparam int PNDW = $clog2(OUT_FIFO_DEPTH + 1);

    logic [IW_W-1:0]  image_width_reg;
    logic [IH_W-1:0]  image_height_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PNDW-1:0]  pend_reg, pend_next;

    logic [EW-1:0]    w_eff;
    logic [IH_W-1:0]  h_eff;
    logic [CW-1:0]    cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [CW-1:0]    col_m2;
    logic             accept;
    meta_t            meta_cur;
    meta_t            meta_s1_reg;

    logic                   lb_valid;
    logic [LINE_WORD_W-1:0] lb_line;
    logic [PIX_W-1:0]       lb_pix;
    logic                   res_push;
    out_item_t              res_item;
    logic                   pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = (pend_reg < PNDW'(OUT_FIFO_DEPTH));
    assign accept    = s_valid && s_ready;
    assign pop       = m_valid && m_ready;

    // sizes in use, clamped to the supported range
    always_comb begin
        if (EW'(image_width_reg) < EW'(MIN_SIZE)) begin
            w_eff = EW'(MIN_SIZE);
        end else if (EW'(image_width_reg) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(image_width_reg);
        end
        if (image_height_reg < IH_W'(MIN_SIZE)) begin
            h_eff = IH_W'(MIN_SIZE);
        end else if (image_height_reg > IH_W'(MAX_HEIGHT)) begin
            h_eff = IH_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end
    end

    always_comb begin
        cur_col = s_data.frame_start ? '0 : col_reg;
        cur_row = s_data.frame_start ? '0 : row_reg;
        col_m2  = cur_col - CW'(2);

        meta_cur.emit       = (cur_row >= ROW_W'(4)) && (EW'(cur_col) >= EW'(4));
        meta_cur.last       = (IH_W'(cur_row) == h_eff - 1'b1)
                              && (EW'(cur_col) == w_eff - 1'b1);
        meta_cur.out_column = COL_OUT_W'(col_m2);
        meta_cur.out_row    = cur_row - ROW_W'(2);

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (EW'(cur_col) + 1'b1 >= w_eff) begin
                col_next = '0;
                row_next = (IH_W'(cur_row) + 1'b1 >= h_eff) ? '0 : cur_row + 1'b1;
            end else begin
                col_next = cur_col + 1'b1;
                row_next = cur_row;
            end
        end

        pend_next = pend_reg;
        if (accept && meta_cur.emit && !pop) begin
            pend_next = pend_reg + 1'b1;
        end else if (!(accept && meta_cur.emit) && pop) begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IW_W'(640);
            image_height_reg <= IH_W'(480);
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_data[IW_W-1:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_data[IH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            meta_s1_reg <= meta_cur;
        end
    end

    gb5_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr   (cur_col),
        .pix_in    (s_data.pixel_in),
        .out_valid (lb_valid),
        .out_line  (lb_line),
        .out_pix   (lb_pix)
    );

    gb5_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (lb_valid),
        .in_line  (lb_line),
        .in_pix   (lb_pix),
        .in_meta  (meta_s1_reg),
        .out_push (res_push),
        .out_item (res_item)
    );

    gb5_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_item (res_item),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_item  (m_data)
    );

endmodule

### hdl/gb5_checker.sv
// gb5_checker: port-level checks of gaussian_blur_5x5, attached by bind.
// Sees only the top level's ports; uses gb5_pkg types.
module gb5_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input gb5_pkg::in_item_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input gb5_pkg::out_item_t             m_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [gb5_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gb5_pkg::*;

    // a result held back by the sink stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // coming out of reset nothing is pending
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && s_ready)
        else $error("block not empty after reset");

    // results sit at least two rows in from the top border
    a_row_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_row >= ROW_W'(2))
        else $error("result on border row");

    // just out of reset, with no pixel transfer yet, no result is shown
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) ##1 !(s_valid && s_ready) |-> !m_valid)
        else $error("result without input");

    // configuration port never stalls
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind gaussian_blur_5x5 gb5_checker u_gb5_checker (.*);

### tb/blur_tb_pkg.sv
// blur_tb_pkg: result scoreboard for the 5x5 Gaussian blur testbench.
// Tracks raster position, line rows and window on its own and queues the filtered pixels due.
// Depends on gb5_pkg for the payload types and field widths.
package blur_tb_pkg;
    import gb5_pkg::*;

    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;
    localparam int unsigned KERNEL_SUM   = 159;
    localparam int unsigned MAX_PRINTS   = 30;

    localparam int unsigned GAUSS_WEIGHT [5][5] = '{
        '{2, 4,  5,  4,  2},
        '{4, 9,  12, 9,  4},
        '{5, 12, 15, 12, 5},
        '{4, 9,  12, 9,  4},
        '{2, 4,  5,  4,  2}
    };

    class blur_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        logic [PIX_W-1:0] line_mem [4][MAX_WIDTH_DEF];
        logic [PIX_W-1:0] win [5][5];
        int unsigned col_cnt;
        int unsigned row_cnt;
        out_item_t filtered_q [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            col_cnt    = 0;
            row_cnt    = 0;
            errors     = 0;
            checked    = 0;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < MAX_WIDTH_DEF; c++)
                    line_mem[r][c] = '0;
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 5; c++)
                    win[r][c] = '0;
        endfunction

        function int unsigned eff_width();
            if (width_reg < MIN_SIZE) return MIN_SIZE;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg < MIN_SIZE) return MIN_SIZE;
            if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
            return height_reg;
        endfunction

        function int unsigned pending();
            return filtered_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = data[IW_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT)
                height_reg = data[IH_W-1:0];
        endfunction

        // one accepted pixel: update window and line rows, queue a result if due
        function void note_pixel(in_item_t px);
            int unsigned w, h, col, row, sum;
            out_item_t res;
            w = eff_width();
            h = eff_height();
            if (px.frame_start) begin
                col_cnt = 0;
                row_cnt = 0;
            end
            col = col_cnt;
            row = row_cnt;
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 4; c++)
                    win[r][c] = win[r][c+1];
            for (int r = 0; r < 4; r++)
                win[r][4] = line_mem[r][col];
            win[4][4] = px.pixel_in;
            for (int r = 0; r < 3; r++)
                line_mem[r][col] = line_mem[r+1][col];
            line_mem[3][col] = px.pixel_in;

            if (row >= 4 && col >= 4) begin
                sum = 0;
                for (int r = 0; r < 5; r++)
                    for (int c = 0; c < 5; c++)
                        sum += GAUSS_WEIGHT[r][c] * win[r][c];
                res.pixel_out  = PIX_W'(sum / KERNEL_SUM);
                res.out_column = COL_OUT_W'(col - 2);
                res.out_row    = ROW_W'(row - 2);
                res.frame_last = (row == h - 1) && (col == w - 1);
                filtered_q.push_back(res);
            end

            // counts past a shrunk size wrap at the next advance
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
            col_cnt = col;
            row_cnt = row;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch: %s", msg);
        endtask

        task check_result(out_item_t got);
            out_item_t exp;
            if (filtered_q.size() == 0) begin
                report($sformatf("unexpected result pix %0d col %0d row %0d last %0b",
                    got.pixel_out, got.out_column, got.out_row, got.frame_last));
                return;
            end
            exp = filtered_q.pop_front();
            checked++;
            if (got.pixel_out !== exp.pixel_out)
                report($sformatf("pixel_out %0d, want %0d (col %0d row %0d)",
                    got.pixel_out, exp.pixel_out, exp.out_column, exp.out_row));
            if (got.out_column !== exp.out_column)
                report($sformatf("out_column %0d, want %0d", got.out_column, exp.out_column));
            if (got.out_row !== exp.out_row)
                report($sformatf("out_row %0d, want %0d", got.out_row, exp.out_row));
            if (got.frame_last !== exp.frame_last)
                report($sformatf("frame_last %0b, want %0b (col %0d row %0d)",
                    got.frame_last, exp.frame_last, exp.out_column, exp.out_row));
        endtask
    endclass

endpackage

### tb/tb_top.sv
// tb_top: stream test of gaussian_blur_5x5 with random idle and stall on both channels.
// Depends on gb5_pkg (payload types, register indexes) and blur_tb_pkg (scoreboard).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gb5_pkg::*;
    import blur_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RANDOM_TARGET = 250;
    localparam int unsigned FRAME_CAP     = 600;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

    typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_HIGH, PAT_LOW, PAT_CHECKER} pattern_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blur_scoreboard sb = new();

    bit          send_idle_en;
    bit          recv_idle_en;
    bit          hold_req;
    int unsigned cycle_count;
    int unsigned in_stall_cycles;
    int unsigned pixels_sent;
    int unsigned random_pixels;
    int unsigned cfg_writes;

    gaussian_blur_5x5 uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count     = 0;
        in_stall_cycles = 0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (s_valid && !s_ready) in_stall_cycles <= in_stall_cycles + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(bit enabled);
        int unsigned roll;
        if (!enabled) return 0;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(10, 4);
        return $urandom_range(40, 11);
    endfunction

    function automatic logic [PIX_W-1:0] pattern_pixel(pattern_t pat, int idx, int w);
        case (pat)
            PAT_RANDOM:  return PIX_W'($urandom);
            PAT_EXTREME: return $urandom_range(1) ? '1 : '0;
            PAT_HIGH:    return '1;
            PAT_LOW:     return '0;
            default:     return (((idx % w) + (idx / w)) % 2) ? '1 : '0;
        endcase
    endfunction

    // result side: checks every transfer, stalls at random or for a long hold-off
    initial begin
        int unsigned stall;
        stall   = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_data);
            if (stall == 0) begin
                if (hold_req) begin
                    hold_req = 1'b0;
                    stall    = HOLD_CYCLES;
                end else begin
                    stall = pick_gap(recv_idle_en);
                end
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input in_item_t px);
        int unsigned gap;
        gap = pick_gap(send_idle_en);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    // start_odds > 0 sprinkles frame_start over the run (1 in start_odds)
    task automatic send_pixels(input int count, input int w, input pattern_t pat,
                               input bit lead_start, input int start_odds);
        in_item_t px;
        for (int i = 0; i < count; i++) begin
            px.pixel_in    = pattern_pixel(pat, i, w);
            px.frame_start = (i == 0) ? lead_start
                           : (start_odds > 0 && $urandom_range(start_odds - 1) == 0);
            send_pixel(px);
        end
    endtask

    task automatic drain();
        int unsigned waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int unsigned phase);
        int unsigned roll, wval, hval, w, h, len, count, nframes;
        bit complete;
        pattern_t pat;
        send_idle_en = ($urandom_range(3) != 0);
        recv_idle_en = ($urandom_range(3) != 0);

        roll = $urandom_range(99);
        wval = (roll < 80) ? $urandom_range(16, 5)
             : (roll < 90) ? $urandom_range(4, 0) : $urandom_range(40, 17);
        roll = $urandom_range(99);
        hval = (roll < 80) ? $urandom_range(9, 5)
             : (roll < 90) ? $urandom_range(4, 0) : $urandom_range(8191, 4097);
        if (phase == 0) begin
            // long hold-off on the result side while pixels keep coming
            wval         = 8;
            hval         = 12;
            send_idle_en = 1'b0;
        end
        if ($urandom_range(1)) begin
            write_reg(REG_IMAGE_WIDTH,
                      CFG_DATA_W'(wval) | (CFG_DATA_W'($urandom_range(31)) << IW_W));
            write_reg(REG_IMAGE_HEIGHT,
                      CFG_DATA_W'(hval) | (CFG_DATA_W'($urandom_range(7)) << IH_W));
        end else begin
            write_reg(REG_IMAGE_HEIGHT,
                      CFG_DATA_W'(hval) | (CFG_DATA_W'($urandom_range(7)) << IH_W));
            write_reg(REG_IMAGE_WIDTH,
                      CFG_DATA_W'(wval) | (CFG_DATA_W'($urandom_range(31)) << IW_W));
        end
        if ($urandom_range(7) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

        w        = sb.eff_width();
        h        = sb.eff_height();
        len      = w * h;
        nframes  = (phase == 0) ? 1 : $urandom_range(3, 1);
        complete = 1'b0;
        if (phase == 0) hold_req = 1'b1;
        for (int f = 0; f < nframes; f++) begin
            pat  = ($urandom_range(3) == 0) ? pattern_t'($urandom_range(4)) : PAT_RANDOM;
            roll = (phase == 0) ? 0 : $urandom_range(99);
            if (roll < 70) begin
                count = (len > FRAME_CAP)
                      ? w * $urandom_range(9, 5) + $urandom_range(w - 1) : len;
                send_pixels(count, w, pat, complete ? bit'($urandom_range(1)) : 1'b1, 0);
                complete = (count == len);
            end else if (roll < 85) begin
                // abandoned frame, the next one restarts with frame_start
                count = $urandom_range((len > FRAME_CAP ? FRAME_CAP : len) - 1, 1);
                send_pixels(count, w, pat, 1'b1, 0);
                complete = 1'b0;
            end else begin
                count = (len > FRAME_CAP) ? FRAME_CAP : len;
                send_pixels(count, w, pat, 1'b1, 16);
                complete = 1'b0;
            end
            random_pixels += count;
        end
        drain();
    endtask

    initial begin
        int unsigned phase;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        hold_req      = 1'b0;
        send_idle_en  = 1'b0;
        recv_idle_en  = 1'b1;
        pixels_sent   = 0;
        random_pixels = 0;
        cfg_writes    = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size: cross one full row, then narrow the row mid-frame
        send_pixels(RESET_WIDTH + 2, RESET_WIDTH, PAT_RANDOM, 1'b1, 0);
        drain();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(9));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(6));
        send_pixels(43, 9, PAT_RANDOM, 1'b0, 0);
        drain();

        // smallest image, upper data bits set
        send_idle_en = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 16'hF800 | CFG_DATA_W'(MIN_SIZE));
        write_reg(REG_IMAGE_HEIGHT, 16'hE000 | CFG_DATA_W'(MIN_SIZE));
        send_pixels(25, 5, PAT_HIGH, 1'b1, 0);
        send_pixels(25, 5, PAT_LOW, 1'b0, 0);      // wraps into a new frame
        send_pixels(25, 5, PAT_CHECKER, 1'b1, 0);
        send_pixels(12, 5, PAT_RANDOM, 1'b1, 0);   // abandoned mid-frame
        send_pixels(25, 5, PAT_EXTREME, 1'b1, 0);
        drain();

        // sizes below the minimum clamp up
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        write_reg(REG_UNUSED, '1);
        send_pixels(50, 5, PAT_RANDOM, 1'b1, 0);
        drain();

        // shrink both sizes mid-frame while counts lie past the new bounds
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(12));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8));
        send_pixels(7 * 12 + 10, 12, PAT_RANDOM, 1'b1, 0);
        drain();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(9));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(6));
        send_pixels(70, 9, PAT_RANDOM, 1'b0, 0);
        drain();

        phase = 0;
        while (random_pixels < RANDOM_TARGET) begin
            random_phase(phase);
            phase++;
        end

        drain();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d filtered pixels never came out", sb.pending()));
        $display("%0d pixel transfers (%0d random, %0d phases), %0d results checked",
            pixels_sent, random_pixels, phase, sb.checked);
        $display("reset size, clamped and mid-frame sizes, %0d reg writes; %0s %0d cycles",
            cfg_writes, "input back-pressured", in_stall_cycles);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
